### rtl/drq_pkg.sv
// Shared types and codes for the DMA request ring queue.
package drq_pkg;

  localparam int DEF_SLOTS = 128;
  localparam int SCAN_LANES = 8;

  localparam logic [15:0] BUDGET_RST = 16'd40960;
  localparam logic [7:0]  SCANLINE_RST = 8'd224;

  localparam int IN_DATA_W = 136;
  localparam int OUT_DATA_W = 128;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_SCANLINE = 1'b1;

  // request modes
  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_COPY = 3'd1;
  localparam logic [2:0] MODE_FILL = 3'd2;
  localparam logic [2:0] MODE_DRAIN_START = 3'd3;
  localparam logic [2:0] MODE_DRAIN_STEP = 3'd4;
  localparam logic [2:0] MODE_QUERY = 3'd5;

  // result status codes
  localparam logic [3:0] ST_ACCEPTED = 4'd0;
  localparam logic [3:0] ST_FULL = 4'd1;
  localparam logic [3:0] ST_ISSUED = 4'd2;
  localparam logic [3:0] ST_EMPTY = 4'd3;
  localparam logic [3:0] ST_BUDGET = 4'd4;
  localparam logic [3:0] ST_SCANLINE = 4'd5;
  localparam logic [3:0] ST_IDLE = 4'd6;
  localparam logic [3:0] ST_BUSY = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  // descriptor ops
  localparam logic [1:0] OP_COPY32 = 2'd0;
  localparam logic [1:0] OP_FILL32 = 2'd1;
  localparam logic [1:0] OP_COPY16 = 2'd2;
  localparam logic [1:0] OP_FILL16 = 2'd3;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  op;
    logic [15:0] size;
    logic [31:0] dest;
    logic [31:0] src;
  } desc_t;

endpackage

### rtl/dma_request_ring_queue.sv
// Top level of the DMA request ring queue: sequencer, slot state and stream ports.
//
// One request enters on the in_ channel (in_tuser = mode, in_tdata = operands)
// and produces exactly one result on the out_ channel (out_tuser = status,
// out_tdata = slot and issued descriptor). The user must write the cfg_ registers
// only while the block is idle; the block does not enforce this. Index 0 is
// the byte budget, index 1 the last scanline. Path of a request from acceptance
// to the result in the output register: clear, drain start, single-slot query
// and unused modes go straight to the finish state; a drain step first makes
// one registered read of the descriptor memory; a copy/fill request or an all-slot
// query steps the 8-slot search window over the busy bits until a hit or a full lap.
// in_tready is high only while the sequencer is idle; one request is in
// flight at a time. A result waits in the output register while out_tready is
// low; the next request may be accepted meanwhile but its result is held back
// until the register frees up.
// Reset frees every slot at once (per-slot busy flops), zeroes cursor and byte
// total and loads the default budget and scanline limit. No clearing pass.
module dma_request_ring_queue #(
  parameter int SLOTS = drq_pkg::DEF_SLOTS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // src[31:0] dest[63:32] size[79:64] fill_value[111:80] wide[112]
  // scanline[120:113] query_all[121] query_slot[128:122], zero pad
  input  logic [drq_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode[2:0]
  input  logic [2:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // slot[6:0] out_src[38:7] out_dest[70:39] out_size[86:71] out_op[88:87]
  // out_value[120:89], zero pad
  output logic [drq_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status[3:0]
  output logic [3:0]                         out_tuser,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [drq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import drq_pkg::*;

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LANES = (SLOTS < SCAN_LANES) ? SLOTS : SCAN_LANES;
  localparam int NSTEPS = (SLOTS + LANES - 1) / LANES;
  localparam int STW = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_FIN
  } state_t;

  state_t            state_r;
  logic [SLOTS-1:0]  busy_r;
  logic [IDXW-1:0]   cursor_r;
  logic [16:0]       total_r;
  logic [15:0]       budget_r;
  logic [7:0]        last_scan_r;

  logic [2:0]        mode_r;
  logic [31:0]       src_r;
  logic [31:0]       dest_r;
  logic [15:0]       size_r;
  logic [31:0]       fill_r;
  logic              wide_r;
  logic [7:0]        scan_r;
  logic              qall_r;
  logic [6:0]        qslot_r;

  logic [IDXW-1:0]   base_r;
  logic [STW-1:0]    step_r;
  logic              found_r;
  logic [IDXW-1:0]   hit_idx_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [3:0]            out_tuser_r;

  logic              scan_hit;
  logic [IDXW-1:0]   scan_idx;
  logic              want_busy;
  logic [IDXW:0]     base_sum;
  logic [IDXW-1:0]   base_nxt;

  desc_t             wr_desc;
  desc_t             rd_desc;
  logic              mem_we;
  logic              mem_re;

  logic              out_free;
  logic              fin_go;
  logic [3:0]        fin_status;
  logic [6:0]        fin_slot;
  desc_t             fin_desc;
  logic [17:0]       drain_sum;
  logic              issue;
  logic              qslot_busy;

  drq_scan #(
    .SLOTS(SLOTS),
    .IDXW (IDXW),
    .LANES(LANES)
  ) u_scan (
    .busy     (busy_r),
    .base     (base_r),
    .want_busy(want_busy),
    .hit      (scan_hit),
    .idx      (scan_idx)
  );

  drq_slot_mem #(
    .DEPTH(SLOTS),
    .AW   (IDXW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(hit_idx_r),
    .wdata(wr_desc),
    .re   (mem_re),
    .raddr(cursor_r),
    .rdata(rd_desc)
  );

  assign want_busy = (mode_r == MODE_QUERY);
  assign base_sum = {1'b0, base_r} + (IDXW+1)'(LANES);
  assign base_nxt = (base_sum >= (IDXW+1)'(SLOTS)) ?
                    IDXW'(base_sum - (IDXW+1)'(SLOTS)) : base_sum[IDXW-1:0];

  assign out_free = !out_tvalid_r || out_tready;
  assign fin_go = (state_r == S_FIN) && out_free;
  assign mem_re = (state_r == S_READ);
  assign drain_sum = {1'b0, total_r} + {2'b00, rd_desc.size};
  assign qslot_busy = (32'(qslot_r) < SLOTS) ? busy_r[IDXW'(qslot_r)] : 1'b0;

  always_comb begin
    wr_desc.src = src_r;
    wr_desc.dest = dest_r;
    wr_desc.size = size_r;
    wr_desc.value = fill_r;
    if (mode_r == MODE_COPY) begin
      wr_desc.op = wide_r ? OP_COPY32 : OP_COPY16;
    end else begin
      wr_desc.op = wide_r ? OP_FILL32 : OP_FILL16;
    end
  end

  assign mem_we = fin_go && found_r && ((mode_r == MODE_COPY) || (mode_r == MODE_FILL));

  always_comb begin
    fin_status = ST_DONE;
    fin_slot = '0;
    fin_desc = '0;
    issue = 1'b0;
    unique case (mode_r)
      MODE_COPY, MODE_FILL: begin
        if (found_r) begin
          fin_status = ST_ACCEPTED;
          fin_slot = 7'(hit_idx_r);
        end else begin
          fin_status = ST_FULL;
        end
      end
      MODE_DRAIN_STEP: begin
        fin_slot = 7'(cursor_r);
        priority if (!busy_r[cursor_r]) begin
          fin_status = ST_EMPTY;
        end else if (drain_sum > {2'b00, budget_r}) begin
          fin_status = ST_BUDGET;
        end else if (scan_r > last_scan_r) begin
          fin_status = ST_SCANLINE;
        end else begin
          fin_status = ST_ISSUED;
          issue = 1'b1;
          fin_desc.dest = rd_desc.dest;
          fin_desc.size = rd_desc.size;
          fin_desc.op = rd_desc.op;
          if ((rd_desc.op == OP_COPY32) || (rd_desc.op == OP_COPY16)) begin
            fin_desc.src = rd_desc.src;
          end else begin
            fin_desc.value = rd_desc.value;
          end
        end
      end
      MODE_QUERY: begin
        if (qall_r) begin
          fin_status = found_r ? ST_BUSY : ST_IDLE;
        end else begin
          fin_status = qslot_busy ? ST_BUSY : ST_IDLE;
        end
      end
      default: begin
        fin_status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r <= '0;
      cursor_r <= '0;
      total_r <= '0;
      budget_r <= BUDGET_RST;
      last_scan_r <= SCANLINE_RST;
      out_tvalid_r <= 1'b0;
      found_r <= 1'b0;
      step_r <= '0;
      base_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BUDGET: budget_r <= cfg_wdata;
          CFG_SCANLINE: last_scan_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_tvalid_r && out_tready && !fin_go) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r <= in_tuser;
            src_r <= in_tdata[31:0];
            dest_r <= in_tdata[63:32];
            size_r <= in_tdata[79:64];
            fill_r <= in_tdata[111:80];
            wide_r <= in_tdata[112];
            scan_r <= in_tdata[120:113];
            qall_r <= in_tdata[121];
            qslot_r <= in_tdata[128:122];
            step_r <= '0;
            found_r <= 1'b0;
            if ((in_tuser == MODE_COPY) || (in_tuser == MODE_FILL)) begin
              base_r <= cursor_r;
              state_r <= S_SCAN;
            end else if ((in_tuser == MODE_QUERY) && in_tdata[121]) begin
              base_r <= '0;
              state_r <= S_SCAN;
            end else if (in_tuser == MODE_DRAIN_STEP) begin
              state_r <= S_READ;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            found_r <= 1'b1;
            hit_idx_r <= scan_idx;
            state_r <= S_FIN;
          end else if (step_r == STW'(NSTEPS - 1)) begin
            state_r <= S_FIN;
          end else begin
            step_r <= step_r + 1'b1;
            base_r <= base_nxt;
          end
        end
        S_READ: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tuser_r <= fin_status;
            out_tdata_r <= {7'd0, fin_desc.value, fin_desc.op, fin_desc.size,
                            fin_desc.dest, fin_desc.src, fin_slot};
            state_r <= S_IDLE;
            if (mode_r == MODE_CLEAR) begin
              busy_r <= '0;
              cursor_r <= '0;
            end
            if (mode_r == MODE_DRAIN_START) begin
              total_r <= '0;
            end
            if (mem_we) begin
              busy_r[hit_idx_r] <= (size_r != 16'd0);
            end
            if (issue) begin
              busy_r[cursor_r] <= 1'b0;
              total_r <= drain_sum[16:0];
              cursor_r <= (32'(cursor_r) == SLOTS - 1) ? '0 : cursor_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

  a_issue_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && issue) |-> (rd_desc.size != 16'd0))
    else $error("issued descriptor with zero size");

  a_issue_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && issue) |=> !busy_r[$past(cursor_r)])
    else $error("issued slot still busy");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (32'(step_r) < NSTEPS))
    else $error("search ran past the ring");

  a_accept_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (size_r != 16'd0)) |=> busy_r[$past(hit_idx_r)])
    else $error("accepted request did not take its slot");

endmodule

### rtl/drq_slot_mem.sv
// Descriptor storage for the request slots, one write and one registered read port.
module drq_slot_mem #(
  parameter int DEPTH = drq_pkg::DEF_SLOTS,
  parameter int AW = $clog2(drq_pkg::DEF_SLOTS)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  drq_pkg::desc_t wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output drq_pkg::desc_t rdata
);
  import drq_pkg::*;

  desc_t mem [DEPTH];
  desc_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/drq_scan.sv
// Window search over the slot busy bits, used for free-slot and any-busy scans.
module drq_scan #(
  parameter int SLOTS = drq_pkg::DEF_SLOTS,
  parameter int IDXW = $clog2(drq_pkg::DEF_SLOTS),
  parameter int LANES = drq_pkg::SCAN_LANES
) (
  input  logic [SLOTS-1:0] busy,
  input  logic [IDXW-1:0]  base,
  input  logic             want_busy,
  output logic             hit,
  output logic [IDXW-1:0]  idx
);
  import drq_pkg::*;

  always_comb begin
    logic [IDXW:0] pos;
    hit = 1'b0;
    idx = base;
    pos = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      pos = {1'b0, base} + (IDXW+1)'(l);
      if (pos >= (IDXW+1)'(SLOTS)) begin
        pos = pos - (IDXW+1)'(SLOTS);
      end
      if (busy[pos[IDXW-1:0]] == want_busy) begin
        hit = 1'b1;
        idx = pos[IDXW-1:0];
      end
    end
  end

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the DMA request ring queue: random request streams against a ring predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import drq_pkg::*;

  localparam int SLOTS = DEF_SLOTS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  typedef struct packed {
    logic [6:0]  qslot;
    logic        qall;
    logic [7:0]  scan;
    logic        wide;
    logic [31:0] fill;
    logic [15:0] size;
    logic [31:0] dest;
    logic [31:0] src;
  } ring_ops_t;

  typedef struct packed {
    logic [2:0] mode;
    ring_ops_t  ops;
  } ring_item_t;

  typedef struct packed {
    logic [3:0] status;
    desc_t      desc;
    logic [6:0] slot;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [2:0] in_tuser = MODE_CLEAR;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [3:0] out_tuser;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_BUDGET;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [31:0] ring_src [SLOTS];
  logic [31:0] ring_dest [SLOTS];
  logic [15:0] ring_size [SLOTS];
  logic [1:0]  ring_op [SLOTS];
  logic [31:0] ring_value [SLOTS];
  int          cursor;
  logic [16:0] drained_bytes;
  logic [15:0] budget;
  logic [7:0]  scan_limit;

  ring_item_t   request_backlog[$];
  ring_result_t pending_results[$];
  ring_item_t   cur_item;
  int queued_total = 0;
  int accepted_total = 0;
  int results_seen = 0;
  int failures = 0;
  int status_seen [16];
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int in_gap = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  dma_request_ring_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic ring_result_t ring_apply(ring_item_t it);
    ring_result_t r;
    int free_slot;
    int pos;
    logic [17:0] sum;
    logic busy;
    r = '0;
    r.status = ST_DONE;
    case (it.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          ring_size[i] = '0;
          ring_src[i] = '0;
          ring_dest[i] = '0;
        end
        cursor = 0;
      end
      MODE_COPY, MODE_FILL: begin
        free_slot = -1;
        pos = cursor;
        for (int i = 0; i < SLOTS; i++) begin
          if (free_slot < 0 && ring_size[pos] == 0) free_slot = pos;
          pos = (pos + 1) % SLOTS;
        end
        if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          ring_dest[free_slot] = it.ops.dest;
          ring_size[free_slot] = it.ops.size;
          if (it.mode == MODE_COPY) begin
            ring_src[free_slot] = it.ops.src;
            ring_op[free_slot] = it.ops.wide ? OP_COPY32 : OP_COPY16;
          end else begin
            ring_value[free_slot] = it.ops.fill;
            ring_op[free_slot] = it.ops.wide ? OP_FILL32 : OP_FILL16;
          end
          r.status = ST_ACCEPTED;
          r.slot = 7'(free_slot);
        end
      end
      MODE_DRAIN_START: drained_bytes = '0;
      MODE_DRAIN_STEP: begin
        r.slot = 7'(cursor);
        sum = 18'(drained_bytes) + 18'(ring_size[cursor]);
        if (ring_size[cursor] == 0) begin
          r.status = ST_EMPTY;
        end else if (sum > 18'(budget)) begin
          r.status = ST_BUDGET;
        end else if (it.ops.scan > scan_limit) begin
          r.status = ST_SCANLINE;
        end else begin
          drained_bytes = sum[16:0];
          r.status = ST_ISSUED;
          r.desc.op = ring_op[cursor];
          r.desc.src = (ring_op[cursor] == OP_COPY32 || ring_op[cursor] == OP_COPY16) ?
                       ring_src[cursor] : '0;
          r.desc.value = (ring_op[cursor] == OP_FILL32 || ring_op[cursor] == OP_FILL16) ?
                         ring_value[cursor] : '0;
          r.desc.dest = ring_dest[cursor];
          r.desc.size = ring_size[cursor];
          ring_src[cursor] = '0;
          ring_dest[cursor] = '0;
          ring_size[cursor] = '0;
          ring_op[cursor] = '0;
          ring_value[cursor] = '0;
          cursor = (cursor + 1) % SLOTS;
        end
      end
      MODE_QUERY: begin
        busy = 1'b0;
        if (it.ops.qall) begin
          for (int i = 0; i < SLOTS; i++)
            if (ring_size[i] != 0) busy = 1'b1;
        end else if (int'(it.ops.qslot) < SLOTS) begin
          busy = ring_size[it.ops.qslot] != 0;
        end
        r.status = busy ? ST_BUSY : ST_IDLE;
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(ring_apply(cur_item));
        accepted_total++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          cur_item = request_backlog.pop_front();
          in_tdata <= cur_item.ops;
          in_tuser <= cur_item.mode;
          in_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 19) == 0) in_gap = $urandom_range(1, 17);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: result %0d %s mismatch: expected %h actual %h",
               $time, results_seen, name, want, got);
      failures++;
    end
  endfunction

  task automatic check_result(ring_result_t got);
    ring_result_t want;
    status_seen[got.status]++;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result: expected none actual status %0d slot %0d",
               $time, got.status, got.slot);
      failures++;
    end else begin
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("slot", want.slot, got.slot);
      compare_field("src", want.desc.src, got.desc.src);
      compare_field("dest", want.desc.dest, got.desc.dest);
      compare_field("size", want.desc.size, got.desc.size);
      compare_field("op", want.desc.op, got.desc.op);
      compare_field("value", want.desc.value, got.desc.value);
    end
    results_seen++;
  endtask

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result({out_tuser, out_tdata[120:0]});
      if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && !calm && $urandom_range(0, 15) == 0) begin
        hold_left = $urandom_range(1, 17);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [15:0] rand_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return '0;
    if (pick < 14) return 16'($urandom);
    if (pick < 17) return 16'hFFFF;
    return 16'($urandom_range(1, 2048));
  endfunction

  function automatic ring_item_t rand_item(logic [2:0] mode);
    ring_item_t it;
    it.mode = mode;
    it.ops.src = $urandom;
    it.ops.dest = $urandom;
    it.ops.size = rand_size();
    it.ops.fill = $urandom;
    it.ops.wide = 1'($urandom);
    it.ops.scan = 8'($urandom);
    it.ops.qall = 1'($urandom);
    it.ops.qslot = 7'($urandom);
    return it;
  endfunction

  function automatic void add(ring_item_t it);
    request_backlog.push_back(it);
    queued_total++;
  endfunction

  function automatic void add_req(logic [2:0] mode, logic [15:0] size, logic wide,
                                  logic [7:0] scan);
    ring_item_t it;
    it = rand_item(mode);
    it.ops.size = size;
    it.ops.wide = wide;
    it.ops.scan = scan;
    add(it);
  endfunction

  function automatic void add_query(logic all, logic [6:0] slot);
    ring_item_t it;
    it = rand_item(MODE_QUERY);
    it.ops.qall = all;
    it.ops.qslot = slot;
    add(it);
  endfunction

  function automatic void add_random_request();
    add(rand_item($urandom_range(0, 1) ? MODE_COPY : MODE_FILL));
  endfunction

  function automatic void queue_random(int count);
    int start;
    int pick;
    ring_item_t it;
    start = queued_total;
    while (queued_total - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        repeat ($urandom_range(1, 20)) add_random_request();
      end else if (pick < 75) begin
        add(rand_item(MODE_DRAIN_START));
        repeat ($urandom_range(1, 25)) begin
          it = rand_item(MODE_DRAIN_STEP);
          if ($urandom_range(0, 9) != 0) it.ops.scan = 8'($urandom_range(0, scan_limit));
          add(it);
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) add(rand_item(MODE_QUERY));
      end else if (pick < 89) begin
        add(rand_item(MODE_CLEAR));
      end else begin
        repeat ($urandom_range(1, 5)) add(rand_item(3'($urandom)));
      end
    end
  endfunction

  task automatic wait_idle();
    while (accepted_total != queued_total || pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CFG_BUDGET) budget = value;
    else scan_limit = value[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    ring_item_t it;
    for (int i = 0; i < SLOTS; i++) begin
      ring_src[i] = '0;
      ring_dest[i] = '0;
      ring_size[i] = '0;
      ring_op[i] = '0;
      ring_value[i] = '0;
    end
    for (int i = 0; i < 16; i++) status_seen[i] = 0;
    cursor = 0;
    drained_bytes = '0;
    budget = BUDGET_RST;
    scan_limit = SCANLINE_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset limits
    add(rand_item(MODE_CLEAR));
    add_query(1'b1, 7'd0);
    add_query(1'b0, 7'd127);
    it = rand_item(MODE_COPY);
    it.ops.size = 16'd16;
    it.ops.wide = 1'b1;
    it.ops.src = 32'hFFFF_FFFF;
    it.ops.dest = 32'h0;
    add(it);
    it = rand_item(MODE_FILL);
    it.ops.size = 16'd40000;
    it.ops.wide = 1'b0;
    it.ops.fill = 32'hFFFF_FFFF;
    add(it);
    it = rand_item(MODE_COPY);
    it.ops.size = 16'hFFFF;
    it.ops.wide = 1'b0;
    it.ops.src = 32'h0;
    it.ops.dest = 32'hFFFF_FFFF;
    add(it);
    add_req(MODE_FILL, 16'd100, 1'b1, 8'd0);
    add_req(MODE_COPY, 16'd0, 1'b1, 8'd0);
    add_query(1'b0, 7'd1);
    add_query(1'b0, 7'd4);
    add_query(1'b1, 7'd4);
    add(rand_item(MODE_DRAIN_START));
    add_req(MODE_DRAIN_STEP, 16'd0, 1'b0, 8'd0);
    add_req(MODE_DRAIN_STEP, 16'd0, 1'b0, 8'd255);
    add_req(MODE_DRAIN_STEP, 16'd0, 1'b0, 8'd224);
    add_req(MODE_DRAIN_STEP, 16'd0, 1'b0, 8'd0);
    add(rand_item(MODE_DRAIN_START));
    add_req(MODE_DRAIN_STEP, 16'd0, 1'b0, 8'd255);
    add(rand_item(MODE_CLEAR));
    add_req(MODE_DRAIN_STEP, 16'd0, 1'b0, 8'd0);
    add(rand_item(MODE_SPARE_A));
    add(rand_item(MODE_SPARE_B));
    add_query(1'b1, 7'd0);
    wait_idle();

    // widest limits; receiver holds off while the sender keeps offering
    write_reg(CFG_BUDGET, 16'hFFFF);
    write_reg(CFG_SCANLINE, 16'd255);
    hold_requests++;
    repeat (130) add_random_request();
    queue_random(200);
    wait_idle();

    // tightest limits
    write_reg(CFG_BUDGET, 16'd0);
    write_reg(CFG_SCANLINE, 16'd0);
    add(rand_item(MODE_CLEAR));
    queue_random(100);
    wait_idle();

    // random limits
    write_reg(CFG_BUDGET, 16'($urandom));
    write_reg(CFG_SCANLINE, 16'($urandom_range(0, 255)));
    add(rand_item(MODE_CLEAR));
    hold_requests++;
    queue_random(250);
    wait_idle();

    // back to reset limits, no idling
    write_reg(CFG_BUDGET, BUDGET_RST);
    write_reg(CFG_SCANLINE, 16'(SCANLINE_RST));
    calm = 1'b1;
    add(rand_item(MODE_CLEAR));
    queue_random(200);

    while (accepted_total != queued_total || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d requests over 5 limit settings: %0d issued, %0d full, %0d empty stops,",
             results_seen, status_seen[ST_ISSUED], status_seen[ST_FULL], status_seen[ST_EMPTY]);
    $display("  %0d budget stops, %0d scanline stops, %0d busy and %0d idle queries, %0d errors",
             status_seen[ST_BUDGET], status_seen[ST_SCANLINE], status_seen[ST_BUSY],
             status_seen[ST_IDLE], failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/drq_pkg.sv
rtl/drq_slot_mem.sv
rtl/drq_scan.sv
rtl/dma_request_ring_queue.sv
tb/sv/testbench.sv
